>>> sv/ffgs_pkg.sv
package ffgs_pkg;

  localparam int ROW_W         = 64;
  localparam int CFG_W         = 6;
  localparam int MAX_WIDTH_DEF = 32;
  localparam int OUTQ_DEPTH    = 4;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd30;

  localparam logic [1:0] CELL_EMPTY   = 2'd0;
  localparam logic [1:0] CELL_TREE    = 2'd1;
  localparam logic [1:0] CELL_BURNING = 2'd2;
  localparam logic [1:0] CELL_BURNT   = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             last;
  } out_t;

  // first result (held row) and second result (incoming row)
  typedef struct packed {
    logic held;
    logic cur;
  } push_t;

endpackage

>>> sv/forest_fire_grid_step_top.sv
// Forest-fire automaton, one generation, streamed a row at a time.
// Input channel (in_valid/in_stall/in_data): one grid row per transfer,
// top to bottom, last_row set on the bottom row. The first row of a grid
// gives no result, each middle row gives the new state of the row above
// it, and the bottom row gives two results: the row above it and then
// itself with last set. A single-row grid gives one result with last set.
// Output channel (out_valid/out_stall/out_data): results in that order.
// Config channel (cfg_valid/cfg_ready/cfg_data): cells per row, always
// ready; values above MAX_WIDTH saturate, zero gives all-zero rows.
// Results of a row are written into the output queue when the row is
// transferred. Both results of a row are computed in the cycle of its
// transfer by two banks of MAX_WIDTH cell lanes, so one row is taken per
// cycle while in_stall is low; the two results of a bottom row are absorbed
// by a four-entry output queue that raises in_stall when fewer than two entries are free.
// Reset clears the stored rows (a new grid starts) and sets the width
// to 30. When the receiver stalls, results wait in the queue and input
// stalls once the queue fills.
module forest_fire_grid_step_top #(
  parameter int MAX_WIDTH = ffgs_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ffgs_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ffgs_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffgs_pkg::CFG_W-1:0]    cfg_data
);

  localparam int ROW_W = ffgs_pkg::ROW_W;
  localparam int CFG_W = ffgs_pkg::CFG_W;

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] lanes_w;
  logic [ROW_W-1:0] row_above_r, row_above_nxt;
  logic [ROW_W-1:0] row_held_r, row_held_nxt;
  logic             above_valid_r, above_valid_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] up_row;
  logic             accept;
  logic             full;
  ffgs_pkg::push_t  push;
  ffgs_pkg::out_t   held_res;
  ffgs_pkg::out_t   cur_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= ffgs_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  assign lanes_w = (width_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;

  // drop lanes beyond the width in force
  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      cur_row[b] = in_data.row_cells[b] && (CFG_W'(b >> 1) < lanes_w);
    end
  end

  assign up_row = above_valid_r ? row_above_r : '0;

  ffgs_row #(.MAX_WIDTH(MAX_WIDTH)) u_row_held (
    .up_row   (up_row),
    .mid_row  (row_held_r),
    .down_row (cur_row),
    .lanes_w  (lanes_w),
    .next_row (held_res.next_row)
  );

  ffgs_row #(.MAX_WIDTH(MAX_WIDTH)) u_row_cur (
    .up_row   (held_valid_r ? row_held_r : '0),
    .mid_row  (cur_row),
    .down_row ('0),
    .lanes_w  (lanes_w),
    .next_row (cur_res.next_row)
  );

  assign held_res.last = 1'b0;
  assign cur_res.last  = 1'b1;

  always_comb begin
    push.held = accept && held_valid_r;
    push.cur  = accept && in_data.last_row;
  end

  always_comb begin
    row_above_nxt   = row_above_r;
    row_held_nxt    = row_held_r;
    above_valid_nxt = above_valid_r;
    held_valid_nxt  = held_valid_r;
    if (accept) begin
      if (in_data.last_row) begin
        // grid done: start over
        row_above_nxt   = '0;
        row_held_nxt    = '0;
        above_valid_nxt = 1'b0;
        held_valid_nxt  = 1'b0;
      end else begin
        row_above_nxt   = held_valid_r ? row_held_r : '0;
        above_valid_nxt = held_valid_r;
        row_held_nxt    = cur_row;
        held_valid_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r   <= '0;
      row_held_r    <= '0;
      above_valid_r <= 1'b0;
      held_valid_r  <= 1'b0;
    end else begin
      row_above_r   <= row_above_nxt;
      row_held_r    <= row_held_nxt;
      above_valid_r <= above_valid_nxt;
      held_valid_r  <= held_valid_nxt;
    end
  end

  ffgs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .held_res  (held_res),
    .cur_res   (cur_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_above_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    above_valid_r |-> held_valid_r)
    else $error("row above stored without held row");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_row |=> !held_valid_r && !above_valid_r)
    else $error("state not cleared after bottom row");

  a_idle_rows_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> (row_held_r == '0) && (row_above_r == '0))
    else $error("stale row data with nothing held");

endmodule

>>> sv/ffgs_lane.sv
module ffgs_lane (
  input  logic       en,
  input  logic       right_en,
  input  logic [1:0] up_cell,
  input  logic [1:0] mid_cell,
  input  logic [1:0] down_cell,
  input  logic [1:0] left_cell,
  input  logic [1:0] right_cell,
  output logic [1:0] next_cell
);

  logic fire;

  always_comb begin
    fire = (up_cell == ffgs_pkg::CELL_BURNING) ||
           (down_cell == ffgs_pkg::CELL_BURNING) ||
           (left_cell == ffgs_pkg::CELL_BURNING) ||
           (right_en && (right_cell == ffgs_pkg::CELL_BURNING));
    if (!en) begin
      next_cell = ffgs_pkg::CELL_EMPTY;
    end else if (mid_cell == ffgs_pkg::CELL_TREE) begin
      next_cell = fire ? ffgs_pkg::CELL_BURNING : ffgs_pkg::CELL_TREE;
    end else begin
      next_cell = ffgs_pkg::CELL_BURNT;
    end
  end

endmodule

>>> sv/ffgs_row.sv
module ffgs_row #(
  parameter int MAX_WIDTH = ffgs_pkg::MAX_WIDTH_DEF
) (
  input  logic [ffgs_pkg::ROW_W-1:0] up_row,
  input  logic [ffgs_pkg::ROW_W-1:0] mid_row,
  input  logic [ffgs_pkg::ROW_W-1:0] down_row,
  input  logic [ffgs_pkg::CFG_W-1:0] lanes_w,
  output logic [ffgs_pkg::ROW_W-1:0] next_row
);

  logic [2*MAX_WIDTH-1:0] lanes_out;

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_lane
    logic [1:0] left_cell;
    logic [1:0] right_cell;

    if (j == 0) begin : g_left_edge
      assign left_cell = ffgs_pkg::CELL_EMPTY;
    end else begin : g_left
      assign left_cell = mid_row[2*j-1 -: 2];
    end

    if (j == MAX_WIDTH-1) begin : g_right_edge
      assign right_cell = ffgs_pkg::CELL_EMPTY;
    end else begin : g_right
      assign right_cell = mid_row[2*j+3 -: 2];
    end

    ffgs_lane u_lane (
      .en         (ffgs_pkg::CFG_W'(j) < lanes_w),
      .right_en   (ffgs_pkg::CFG_W'(j + 1) < lanes_w),
      .up_cell    (up_row[2*j+1 -: 2]),
      .mid_cell   (mid_row[2*j+1 -: 2]),
      .down_cell  (down_row[2*j+1 -: 2]),
      .left_cell  (left_cell),
      .right_cell (right_cell),
      .next_cell  (lanes_out[2*j+1 -: 2])
    );
  end

  // merge lanes into one row, unused upper lanes zero
  assign next_row = ffgs_pkg::ROW_W'(lanes_out);

endmodule

>>> sv/ffgs_outq.sv
module ffgs_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  ffgs_pkg::push_t     push,
  input  ffgs_pkg::out_t      held_res,
  input  ffgs_pkg::out_t      cur_res,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output ffgs_pkg::out_t      out_data
);

  localparam int DEPTH = ffgs_pkg::OUTQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ffgs_pkg::out_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] cur_ptr;
  logic             pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  // leave room for two results per transfer
  assign full      = (count_r > CNT_W'(DEPTH - 2));
  assign cur_ptr   = wr_ptr_r + PTR_W'(push.held);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.held) + PTR_W'(push.cur);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.held) + CNT_W'(push.cur) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.held) begin
      mem_r[wr_ptr_r] <= held_res;
    end
    if (push.cur) begin
      mem_r[cur_ptr] <= cur_res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("output queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(push.held || push.cur))
    else $error("push into full output queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with count");

endmodule
